### rtl/dctc_pkg.sv
`timescale 1ns / 1ps
package dctc_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned SPT_W   = 8;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SECONDS_PER_TICK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_INTERVAL    = CFG_IDX_W'(1);

    localparam logic [SPT_W-1:0]  SPT_RESET  = SPT_W'(8);
    localparam logic [DATA_W-1:0] SYNC_RESET = DATA_W'(450);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_NOM,
        S_BR,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

### rtl/dctc_in_if.sv
`timescale 1ns / 1ps
interface dctc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] rtc_seconds;

    modport source (output valid, output rtc_seconds, input ready);
    modport sink   (input valid, input rtc_seconds, output ready);
endinterface

### rtl/dctc_out_if.sv
`timescale 1ns / 1ps
interface dctc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] estimated_time;
    logic        did_sync;

    modport source (output valid, output estimated_time, output did_sync, input ready);
    modport sink   (input valid, input estimated_time, input did_sync, output ready);
endinterface

### rtl/dctc_cfg_if.sv
`timescale 1ns / 1ps
interface dctc_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/drift_corrected_tick_clock_core.sv
`timescale 1ns / 1ps
// Tick clock with RTC drift correction. Each input request is one sleep-cycle tick and
// yields exactly one result: the RTC time on a sync tick, otherwise the sync time plus the
// drift-corrected seconds since that sync. A single one-bit-per-cycle divider finds
// tick_count mod sync_interval (32 steps) and, on sync ticks past the second, the
// Q(32-FRAC_BITS).FRAC_BITS drift factor (32+FRAC_BITS steps); one 32x32 multiplier,
// used twice, forms the nominal seconds and the corrected offset. A tick runs from accept to
// result through S_MOD, which waits out the divider steps for the phase, then S_NOM for the
// nominal product, S_BR for the corrected offset and S_FIN for the result register. A sync
// tick that recomputes the drift adds the 32+FRAC_BITS-step divide in S_DIV before S_FIN;
// with sync_interval zero S_MOD and the phase divide are skipped. The input is ready again
// as soon as the result is registered. The result sits in an output register, so a new tick
// may be accepted while the previous result waits; that tick then holds in its last step
// until the output register frees up. Configuration writes are always taken.
module drift_corrected_tick_clock_core import dctc_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dctc_in_if.sink   i_in,
    dctc_out_if.source o_out,
    dctc_cfg_if.sink  i_cfg
);

    localparam int unsigned DW = DATA_W + FRAC_BITS;
    localparam int unsigned CW = $clog2(DW + 1);
    localparam logic [DATA_W-1:0] UNIT = DATA_W'(1) << FRAC_BITS;

    t_state            r_state, n_state;
    logic [SPT_W-1:0]  r_spt;
    logic [DATA_W-1:0] r_sync_int;
    logic [DATA_W-1:0] r_tick_count, n_tick_count;
    logic [DATA_W-1:0] r_ticks_at_sync, n_ticks_at_sync;
    logic [DATA_W-1:0] r_time_at_sync, n_time_at_sync;
    logic [DATA_W-1:0] r_drift, n_drift;
    logic              r_sync, n_sync;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_rtc;
    logic [DATA_W-1:0] r_nom;
    logic [2*DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_est, n_est;
    logic              r_did, n_did;

    logic              w_accept;
    logic              w_load;
    logic              w_div_start;
    logic [DW-1:0]     w_dividend;
    logic [DATA_W-1:0] w_divisor;
    logic [CW-1:0]     w_steps;
    t_div_status       w_div_st;
    logic [DW-1:0]     w_quo;
    logic [DATA_W-1:0] w_rem;
    logic [DATA_W-1:0] w_mul_a;
    logic [DATA_W-1:0] w_mul_b;
    logic [2*DATA_W-1:0] w_mul_p;
    logic [DATA_W-1:0] w_elapsed;
    logic [DATA_W-1:0] w_actual;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_load      = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    assign w_elapsed = r_tick_count - r_ticks_at_sync;
    assign w_actual  = r_rtc - r_time_at_sync;

    // shared multiplier: nominal seconds first, then the corrected offset
    assign w_mul_a = (r_state == S_NOM) ? w_elapsed : r_nom;
    assign w_mul_b = (r_state == S_NOM) ? {{(DATA_W-SPT_W){1'b0}}, r_spt} : r_drift;
    assign w_mul_p = w_mul_a * w_mul_b;

    // shared divider: phase of the tick count, then the drift ratio
    assign w_div_start = (w_accept && r_sync_int != '0)
                      || ((r_state == S_BR) && r_sync && r_tick_count > DATA_W'(1)
                          && r_nom != '0);
    assign w_dividend = (r_state == S_BR) ? {w_actual, {FRAC_BITS{1'b0}}}
                                          : {r_tick_count, {FRAC_BITS{1'b0}}};
    assign w_divisor  = (r_state == S_BR) ? r_nom : r_sync_int;
    assign w_steps    = (r_state == S_BR) ? CW'(DW) : CW'(DATA_W);

    dctc_divider #(
        .DW (DW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .i_steps     (w_steps),
        .o_status    (w_div_st),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_comb begin
        n_state         = r_state;
        n_sync          = r_sync;
        n_drift         = r_drift;
        n_tick_count    = r_tick_count;
        n_ticks_at_sync = r_ticks_at_sync;
        n_time_at_sync  = r_time_at_sync;
        n_out_valid     = r_out_valid && !o_out.ready;
        n_est           = r_est;
        n_did           = r_did;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_sync_int == '0) begin
                        n_sync  = (r_tick_count == '0);
                        n_state = S_NOM;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (w_div_st.done) begin
                    n_sync  = (w_rem == '0);
                    n_state = S_NOM;
                end
            end
            S_NOM: begin
                n_state = S_BR;
            end
            S_BR: begin
                if (!r_sync) begin
                    n_state = S_FIN;
                end else if (r_tick_count <= DATA_W'(1)) begin
                    n_drift = UNIT;
                    n_state = S_FIN;
                end else if (r_nom == '0) begin
                    n_drift = '1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_st.done) begin
                    // saturate a ratio that does not fit the factor
                    n_drift = (w_quo[DW-1:DATA_W] != '0) ? '1 : w_quo[DATA_W-1:0];
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_out_valid  = 1'b1;
                    n_did        = r_sync;
                    n_tick_count = r_tick_count + DATA_W'(1);
                    if (r_sync) begin
                        n_est           = r_rtc;
                        n_time_at_sync  = r_rtc;
                        n_ticks_at_sync = r_tick_count;
                    end else begin
                        n_est = r_time_at_sync + r_prod[FRAC_BITS +: DATA_W];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_sync          <= 1'b0;
            r_drift         <= UNIT;
            r_tick_count    <= '0;
            r_ticks_at_sync <= '0;
            r_time_at_sync  <= '0;
            r_out_valid     <= 1'b0;
            r_spt           <= SPT_RESET;
            r_sync_int      <= SYNC_RESET;
        end else begin
            r_state         <= n_state;
            r_sync          <= n_sync;
            r_drift         <= n_drift;
            r_tick_count    <= n_tick_count;
            r_ticks_at_sync <= n_ticks_at_sync;
            r_time_at_sync  <= n_time_at_sync;
            r_out_valid     <= n_out_valid;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_SECONDS_PER_TICK: r_spt      <= i_cfg.data[SPT_W-1:0];
                    CFG_SYNC_INTERVAL:    r_sync_int <= i_cfg.data;
                    default: begin
                        // drop writes to unknown registers
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rtc <= i_in.rtc_seconds;
        end
        if (r_state == S_NOM) begin
            r_nom <= w_mul_p[DATA_W-1:0];
        end
        if (r_state == S_BR) begin
            r_prod <= w_mul_p;
        end
        r_est <= n_est;
        r_did <= n_did;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.estimated_time = r_est;
    assign o_out.did_sync       = r_did;

    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_st.busy)
        else $error("divider busy while no tick is in progress");

    a_one_tick_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready right after a tick was accepted");

    a_sync_result_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_did) |-> (r_est == r_time_at_sync))
        else $error("sync result differs from latched sync time");

    a_count_only_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_load |=> (r_tick_count == $past(r_tick_count)))
        else $error("tick count moved without a result");

endmodule

### rtl/dctc_divider.sv
`timescale 1ns / 1ps
module dctc_divider import dctc_pkg::*; #(
    parameter int unsigned DW = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DW-1:0]              i_dividend,
    input  logic [DATA_W-1:0]          i_divisor,
    input  logic [$clog2(DW+1)-1:0]    i_steps,
    output t_div_status                o_status,
    output logic [DW-1:0]              o_quotient,
    output logic [DATA_W-1:0]          o_remainder
);

    localparam int unsigned CW = $clog2(DW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DW-1:0]     r_quo;
    logic [DATA_W-1:0] r_div;

    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_diff;
    logic              w_ge;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;
    assign o_remainder   = r_rem;

    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == CW'(1)) |=> (r_done && !r_busy))
        else $error("divider did not finish after its last step");

endmodule

### verif/drift_corrected_tick_clock_checker.sv
`timescale 1ns / 1ps
module drift_corrected_tick_clock_checker import dctc_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dctc_in_if   i_in,
    dctc_out_if  i_out,
    dctc_cfg_if  i_cfg,
    output int   o_mismatches,
    output int   o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] estimated_time;
        logic              did_sync;
    } tick_estimate_t;

    localparam logic [DATA_W-1:0] UNITY     = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] SATURATED = '1;

    logic [SPT_W-1:0]  seconds_per_tick;
    logic [DATA_W-1:0] sync_interval;
    logic [DATA_W-1:0] tick_count;
    logic [DATA_W-1:0] ticks_at_sync;
    logic [DATA_W-1:0] time_at_sync;
    logic [DATA_W-1:0] drift_factor;

    tick_estimate_t pending_estimates[$];
    int             mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // Actual over nominal seconds since the last sync, saturated.
    function automatic logic [DATA_W-1:0] drift_ratio(input logic [DATA_W-1:0] rtc);
        logic [DATA_W-1:0] actual;
        logic [DATA_W-1:0] nominal;
        logic [63:0]       quotient;
        actual  = rtc - time_at_sync;
        nominal = (tick_count - ticks_at_sync) * DATA_W'(seconds_per_tick);
        if (nominal == '0) begin
            return SATURATED;
        end
        quotient = ({32'b0, actual} << FRAC_BITS) / {32'b0, nominal};
        if (quotient[63:32] != '0) begin
            return SATURATED;
        end
        return quotient[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t: %s: got %h, want %h (tick result)", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic estimate_tick(input logic [DATA_W-1:0] rtc);
        tick_estimate_t    estimate;
        logic              sync_now;
        logic [DATA_W-1:0] nominal;
        logic [63:0]       product;
        if (sync_interval == '0) begin
            sync_now = (tick_count == '0);
        end else begin
            sync_now = ((tick_count % sync_interval) == '0);
        end
        if (sync_now) begin
            drift_factor  = (tick_count > 1) ? drift_ratio(rtc) : UNITY;
            time_at_sync  = rtc;
            ticks_at_sync = tick_count;
            estimate.estimated_time = rtc;
        end else begin
            nominal = (tick_count - ticks_at_sync) * DATA_W'(seconds_per_tick);
            product = {32'b0, nominal} * {32'b0, drift_factor};
            estimate.estimated_time = time_at_sync + DATA_W'(product >> FRAC_BITS);
        end
        estimate.did_sync = sync_now;
        tick_count = tick_count + 1;
        pending_estimates.push_back(estimate);
    endtask

    always @(posedge i_clk) begin
        tick_estimate_t want;
        if (!i_rst_n) begin
            seconds_per_tick = SPT_RESET;
            sync_interval    = SYNC_RESET;
            tick_count       = '0;
            ticks_at_sync    = '0;
            time_at_sync     = '0;
            drift_factor     = UNITY;
            pending_estimates.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_SECONDS_PER_TICK) begin
                    seconds_per_tick = i_cfg.data[SPT_W-1:0];
                end else if (i_cfg.index == CFG_SYNC_INTERVAL) begin
                    sync_interval = i_cfg.data;
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (pending_estimates.size() == 0) begin
                    report_mismatch("result with no tick pending", i_out.estimated_time, '0);
                end else begin
                    want = pending_estimates.pop_front();
                    if (i_out.estimated_time !== want.estimated_time) begin
                        report_mismatch("estimated_time", i_out.estimated_time,
                                        want.estimated_time);
                    end
                    if (i_out.did_sync !== want.did_sync) begin
                        report_mismatch("did_sync", DATA_W'(i_out.did_sync),
                                        DATA_W'(want.did_sync));
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                estimate_tick(i_in.rtc_seconds);
            end
        end
        o_pending <= pending_estimates.size();
    end

endmodule

### verif/drift_corrected_tick_clock_core_test.sv
`timescale 1ns / 1ps
module drift_corrected_tick_clock_core_test;
    import dctc_pkg::*;

    localparam int unsigned FRAC_BITS = 16;
    localparam int TOTAL_TICKS         = 1050;
    localparam int STEADY_TICKS        = 120;
    localparam int IDLE_LIMIT          = 4000;
    localparam int BACKPRESSURE_CYCLES = 400;
    localparam int SETTLE_CYCLES       = 100;
    localparam int PRESSURE_PHASE      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;

    logic clk = 1'b0;
    logic rst_n;

    dctc_in_if  tick_ch ();
    dctc_out_if time_ch ();
    dctc_cfg_if cfg_ch ();

    int mismatches;
    int pending;
    int ticks_sent = 0;
    int idle_cycles = 0;
    bit steady = 1'b0;
    bit backpressure_req = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    drift_corrected_tick_clock_core #(.FRAC_BITS(FRAC_BITS)) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (tick_ch),
        .o_out   (time_ch),
        .i_cfg   (cfg_ch)
    );

    drift_corrected_tick_clock_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (tick_ch),
        .i_out        (time_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (time_ch.valid && time_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("drift_corrected_tick_clock_core_test: done, errors");
            $finish;
        end
    end

    // Result side: random stalls, one long hold on request.
    initial begin
        time_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (backpressure_req) begin
                backpressure_req = 1'b0;
                time_ch.ready <= 1'b0;
                repeat (BACKPRESSURE_CYCLES) @(posedge clk);
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                time_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                time_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick(input logic [DATA_W-1:0] rtc);
        if (!steady && $urandom_range(0, 3) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.rtc_seconds <= rtc;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        ticks_sent++;
        if (ticks_sent >= TOTAL_TICKS - STEADY_TICKS) begin
            steady = 1'b1;
        end
    endtask

    // Drop the request and wait for every pending result.
    task automatic drain_ticks();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        logic [DATA_W-1:0] true_time;
        logic [DATA_W-1:0] interval;
        logic [SPT_W-1:0]  spt;
        int                drift_pm;
        int                step;
        int                burst;
        int                phase;

        rst_n               <= 1'b0;
        tick_ch.valid       <= 1'b0;
        tick_ch.rtc_seconds <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero interval: only the very first tick syncs; estimates wrap past 2^32.
        write_reg(CFG_SYNC_INTERVAL, '0);
        write_reg(CFG_SECONDS_PER_TICK, DATA_W'(255));
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'h0000_0000);
        send_tick(32'hAAAA_AAAA);
        send_tick(32'h5555_5555);
        drain_ticks();

        // Every tick syncs; a big jump saturates the drift factor.
        write_reg(CFG_SYNC_INTERVAL, DATA_W'(1));
        send_tick(32'h0000_0000);
        send_tick(32'h1234_5678);
        send_tick(32'hFFFF_0000);
        send_tick(32'hFFFF_0100);
        drain_ticks();

        // Zero seconds per tick: zero nominal time, estimate holds at the sync time.
        write_reg(CFG_SECONDS_PER_TICK, 32'hFFFF_FF00);
        send_tick(32'h0001_0000);
        drain_ticks();
        write_reg(CFG_SYNC_INTERVAL, DATA_W'(3));
        send_tick(32'h0002_0000);
        send_tick(32'h5555_5555);
        send_tick(32'hAAAA_AAAA);
        send_tick(32'h0002_0010);
        drain_ticks();

        write_reg(CFG_SECONDS_PER_TICK, DATA_W'(1));
        write_reg(CFG_SYNC_INTERVAL, '1);
        send_tick(32'hAAAA_AAAA);
        send_tick(32'h5555_5555);
        send_tick(32'hFFFF_FFFF);
        drain_ticks();

        write_reg(CFG_SECONDS_PER_TICK, DATA_W'(255));
        write_reg(CFG_SYNC_INTERVAL, DATA_W'(2));
        send_tick(32'h0010_0000);
        send_tick(32'h0000_0000);
        send_tick(32'h0010_0200);
        send_tick(32'hFFFF_FFFF);
        drain_ticks();

        // Random phases: RTC follows a drifting true time, with some noise ticks.
        true_time = $urandom();
        phase = 0;
        while (ticks_sent < TOTAL_TICKS) begin
            case ($urandom_range(0, 9))
                0:       spt = SPT_W'(1);
                1:       spt = SPT_W'(255);
                2:       spt = '0;
                default: spt = SPT_W'($urandom_range(1, 255));
            endcase
            case ($urandom_range(0, 9))
                0:       interval = '0;
                1:       interval = '1;
                2:       interval = DATA_W'($urandom_range(100, 600));
                default: interval = DATA_W'($urandom_range(1, 12));
            endcase
            write_reg(CFG_SECONDS_PER_TICK, ($urandom() & 32'hFFFF_FF00) | DATA_W'(spt));
            write_reg(CFG_SYNC_INTERVAL, interval);
            if ($urandom_range(0, 4) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(int'(CFG_SYNC_INTERVAL) + 1, 255)),
                          $urandom());
            end
            if (phase == PRESSURE_PHASE) begin
                backpressure_req = 1'b1;
            end
            drift_pm = int'($urandom_range(0, 200)) - 100;
            burst = $urandom_range(20, 60);
            for (int i = 0; i < burst && ticks_sent < TOTAL_TICKS; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_tick($urandom());
                end else begin
                    send_tick(true_time);
                end
                step = int'(spt) + (int'(spt) * drift_pm) / 1000 +
                       int'($urandom_range(0, 2)) - 1;
                true_time = true_time + DATA_W'(step);
            end
            drain_ticks();
            phase++;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("drift_corrected_tick_clock_core_test: done, clean");
        end else begin
            $display("drift_corrected_tick_clock_core_test: done, errors");
        end
        $finish;
    end

endmodule
